/* rtl/core/fbpa_pkg.sv */
package fbpa_pkg;

  // Defaults and fixed constants
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ALIGN_UNIT     = 8;

  localparam logic [15:0] BLOCK_BYTES_RST = 16'd64;
  localparam logic [8:0]  BLOCK_COUNT_RST = 9'd256;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Opcodes (code 3 is unused)
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_INVALID   = 2'd1;
  localparam logic [1:0] STAT_DOUBLE    = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } fbpa_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_bytes;
    logic [7:0]  release_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted_index;
    logic [8:0] used_count;
    logic       pool_full;
    logic       pool_empty;
  } out_item_t;

endpackage

/* rtl/core/fbpa_ram.sv */
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fbpa_cfg.sv */
module fbpa_cfg #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [16:0]                         aligned_bytes,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]     eff_count,
  output logic                                count_wr
);

  import fbpa_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);

  logic [15:0] block_bytes_r;
  logic [8:0]  block_count_r;
  logic [15:0] count_wide;
  logic [15:0] eff_wide;

  assign count_wr = cfg_we && (cfg_index == REG_BLOCK_COUNT);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BLOCK_BYTES_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_BYTES: block_bytes_r <= cfg_wdata;
        REG_BLOCK_COUNT: block_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Block size rounded up to the alignment unit
  assign aligned_bytes = ({1'b0, block_bytes_r} + 17'(ALIGN_UNIT - 1))
                         & ~17'(ALIGN_UNIT - 1);

  // Count clamped to 1..MAX_BLOCKS
  always_comb begin
    count_wide = 16'(block_count_r);
    if (count_wide == 16'd0) begin
      eff_wide = 16'd1;
    end else if (count_wide > 16'(MAX_BLOCKS)) begin
      eff_wide = 16'(MAX_BLOCKS);
    end else begin
      eff_wide = count_wide;
    end
  end

  assign eff_count = eff_wide[DEPTH_W-1:0];

endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator.
// Input channel (in_valid/in_ready/in_data): one request per transfer, opcode
// allocate, free or reinitialize. Result channel (out_valid/out_ready/out_data):
// exactly one result per request, in request order: status, granted block,
// usage count and full/empty flags.
// Config port (cfg_we/cfg_index/cfg_wdata): block size and block count, written
// while no request is in flight. Writing the block count rebuilds the pool.
// Timing: a request is taken in S_IDLE, where the free stack and the allocation
// mark are read; the read data arrive in S_EXEC, and the result lands in the
// output register once that register is empty or being drained. No new
// request is taken until the last one has left S_EXEC, a pace set by the
// registered read of the mark and free-stack memories ahead of their write-back.
// The allocation marks sit in a memory that is cleared one entry per cycle:
// after reset, after a reinitialize request and after a block count write,
// in_ready stays low until every entry is cleared. The free stack needs no
// clearing; a low-water mark tells which slots still hold their initial index.
// When the receiver stalls, the finished result waits in the output register;
// one more request may be taken and waits for that register to empty.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbpa_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbpa_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import fbpa_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);

  // Configuration
  logic [16:0]        aligned_bytes;
  logic [DEPTH_W-1:0] eff_count;
  logic               count_wr;

  fbpa_cfg #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .aligned_bytes(aligned_bytes),
    .eff_count    (eff_count),
    .count_wr     (count_wr)
  );

  // Control and bookkeeping registers
  fbpa_state_t        state_r, state_nxt;
  in_item_t           item_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] used_r, used_nxt;
  logic [DEPTH_W-1:0] lw_r, lw_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]   pop_pos_r;
  logic               pop_in_mem_r;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;

  // Memory ports
  logic               stack_we, stack_re;
  logic [IDX_W-1:0]   stack_waddr, stack_wdata, stack_raddr, stack_rdata;
  logic               mark_we, mark_re;
  logic [IDX_W-1:0]   mark_waddr, mark_raddr;
  logic               mark_wdata, mark_rdata;

  // Datapath helpers
  logic               accept, exec_fire, clr_last;
  logic [DEPTH_W-1:0] top_pos;
  logic [15:0]        in_rel_wide, rel_wide, n_wide, pop_wide, used_wide;
  logic [IDX_W-1:0]   pop_val, rel_idx;
  logic               req_bad, rel_bad;
  logic [1:0]         status;
  logic [7:0]         granted;

  fbpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_BLOCKS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(stack_wdata),
    .re   (stack_re),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  fbpa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_BLOCKS)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .re   (mark_re),
    .raddr(mark_raddr),
    .rdata(mark_rdata)
  );

  // Handshake
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign clr_last  = (clr_cnt_r == IDX_W'(MAX_BLOCKS - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read addresses, issued on the transfer
  assign top_pos     = depth_r - DEPTH_W'(1);
  assign in_rel_wide = 16'(in_data.release_index);
  assign stack_re    = accept;
  assign stack_raddr = top_pos[IDX_W-1:0];
  assign mark_re     = accept;
  assign mark_raddr  = in_rel_wide[IDX_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = (item_r.opcode == OP_REINIT) ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (count_wr) begin
      state_nxt = S_CLEAR;
    end
  end

  // Clearing sweep counter
  assign clr_cnt_nxt = (state_r == S_CLEAR && !count_wr) ? clr_cnt_r + IDX_W'(1) : '0;

  // Operation decode and memory updates
  always_comb begin
    rel_wide = 16'(item_r.release_index);
    n_wide   = 16'(eff_count);
    rel_idx  = rel_wide[IDX_W-1:0];
    rel_bad  = (rel_wide >= n_wide);
    req_bad  = (item_r.request_bytes == 16'd0) ||
               ({1'b0, item_r.request_bytes} > aligned_bytes);
    pop_val  = pop_in_mem_r ? stack_rdata : pop_pos_r;
    pop_wide = 16'(pop_val);

    status      = STAT_INVALID;
    granted     = 8'd0;
    depth_nxt   = depth_r;
    used_nxt    = used_r;
    lw_nxt      = lw_r;
    stack_we    = 1'b0;
    stack_waddr = depth_r[IDX_W-1:0];
    stack_wdata = rel_idx;
    mark_we     = 1'b0;
    mark_waddr  = clr_cnt_r;
    mark_wdata  = 1'b0;

    if (state_r == S_CLEAR) begin
      depth_nxt = eff_count;
      used_nxt  = '0;
      lw_nxt    = eff_count;
      mark_we   = 1'b1;
    end else if (exec_fire) begin
      case (item_r.opcode)
        OP_ALLOC: begin
          if (req_bad) begin
            status = STAT_INVALID;
          end else if (depth_r == '0) begin
            status = STAT_EXHAUSTED;
          end else begin
            status     = STAT_OK;
            depth_nxt  = top_pos;
            lw_nxt     = (top_pos < lw_r) ? top_pos : lw_r;
            used_nxt   = used_r + DEPTH_W'(1);
            granted    = pop_wide[7:0];
            mark_we    = 1'b1;
            mark_waddr = pop_val;
            mark_wdata = 1'b1;
          end
        end
        OP_FREE: begin
          if (rel_bad) begin
            status = STAT_INVALID;
          end else if (!mark_rdata) begin
            status = STAT_DOUBLE;
          end else begin
            status     = STAT_OK;
            mark_we    = 1'b1;
            mark_waddr = rel_idx;
            mark_wdata = 1'b0;
            if (used_r != '0) begin
              used_nxt = used_r - DEPTH_W'(1);
            end
            if (depth_r < DEPTH_W'(MAX_BLOCKS)) begin
              stack_we  = 1'b1;
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
        end
        OP_REINIT: begin
          status    = STAT_OK;
          depth_nxt = eff_count;
          used_nxt  = '0;
          lw_nxt    = eff_count;
        end
        default: status = STAT_INVALID;
      endcase
    end
  end

  // Result fields
  always_comb begin
    used_wide                  = 16'(used_nxt);
    out_data_nxt.status        = status;
    out_data_nxt.granted_index = granted;
    out_data_nxt.used_count    = used_wide[8:0];
    out_data_nxt.pool_full     = (used_nxt == eff_count);
    out_data_nxt.pool_empty    = (used_nxt == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      used_r      <= '0;
      lw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      depth_r   <= depth_nxt;
      used_r    <= used_nxt;
      lw_r      <= lw_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r       <= in_data;
      pop_pos_r    <= top_pos[IDX_W-1:0];
      pop_in_mem_r <= (top_pos >= lw_r);
    end
    if (exec_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
